>>> hw/rtl/scfla_pkg.sv
package scfla_pkg;

  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 13;
  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERSIZE  = 2'd1;
  localparam status_t ST_EXHAUSTED = 2'd2;
  localparam status_t ST_BAD       = 2'd3;

  localparam logic OP_FREE = 1'b1;

  typedef struct packed {
    logic    accept;
    logic    look;
    logic    rd_link;
    logic    pop;
    logic    mul1;
    logic    mul2;
    logic    push;
    logic    init_step;
    logic    res_we;
    logic    res_grant;
    status_t res_status;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic over;
    logic is_free;
    logic head_null;
    logic in_range;
    logic aligned;
    logic init_last;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/scfla_ctrl.sv
module scfla_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  scfla_pkg::sts_t sts,
  output scfla_pkg::cmd_t cmd
);
  import scfla_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_ALINK = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.zero) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_BAD;
          state_next     = S_FIN;
        end else if (sts.over) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_OVERSIZE;
          state_next     = S_FIN;
        end else if (!sts.is_free) begin
          if (sts.head_null) begin
            cmd.res_we     = 1'b1;
            cmd.res_status = ST_EXHAUSTED;
            state_next     = S_FIN;
          end else begin
            cmd.rd_link = 1'b1;
            state_next  = S_ALINK;
          end
        end else if (!sts.in_range) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_BAD;
          state_next     = S_FIN;
        end else begin
          state_next = S_MUL1;
        end
      end
      S_ALINK: begin
        cmd.pop        = 1'b1;
        cmd.res_we     = 1'b1;
        cmd.res_grant  = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_FIN;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_FCHK;
      end
      S_FCHK: begin
        cmd.res_we = 1'b1;
        if (sts.aligned) begin
          cmd.push       = 1'b1;
          cmd.res_status = ST_OK;
        end else begin
          cmd.res_status = ST_BAD;
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/scfla_dp.sv
module scfla_dp #(
  parameter int NUM_CLASSES      = 8,
  parameter int MIN_BLOCK        = 8,
  parameter int BLOCKS_PER_CLASS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  scfla_pkg::cmd_t                  cmd,
  output scfla_pkg::sts_t                  sts,
  input  logic                             opcode,
  input  logic [scfla_pkg::SIZE_W-1:0]     request_size,
  input  logic [scfla_pkg::ADDR_W-1:0]     block_address,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [scfla_pkg::ADDR_W-1:0]     granted_address,
  output scfla_pkg::status_t               status
);
  import scfla_pkg::*;

  localparam int TOTAL     = NUM_CLASSES * BLOCKS_PER_CLASS;
  localparam int NULL_SLOT = TOTAL;
  localparam int SW        = $clog2(TOTAL + 1);
  localparam int SAW       = $clog2(TOTAL);
  localparam int CW        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int KW        = $clog2(BLOCKS_PER_CLASS);
  localparam int QW        = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int MAX_BSZ   = NUM_CLASSES * MIN_BLOCK;
  localparam int BW        = $clog2(MAX_BSZ + 1);
  localparam int POOL      = MIN_BLOCK * BLOCKS_PER_CLASS * (NUM_CLASSES * (NUM_CLASSES + 1) / 2);
  localparam int PW        = $clog2(POOL + 1);
  localparam int XW        = ((PW > ADDR_W) ? PW : ADDR_W) + 1;
  localparam int OW        = $clog2(MAX_BSZ * BLOCKS_PER_CLASS);
  localparam int PRW       = OW + 1;

  logic [PW-1:0] base_tab  [NUM_CLASSES];
  logic [PW-1:0] end_tab   [NUM_CLASSES];
  logic [BW-1:0] bsz_tab   [NUM_CLASSES];
  logic [OW-1:0] rcp_tab   [NUM_CLASSES];
  logic [SW-1:0] first_tab [NUM_CLASSES];

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cls
    localparam int BSZ  = (g + 1) * MIN_BLOCK;
    localparam int BASE = MIN_BLOCK * BLOCKS_PER_CLASS * (g * (g + 1) / 2);
    localparam int REND = BASE + BSZ * BLOCKS_PER_CLASS;
    localparam int RCP  = ((1 << OW) + BSZ - 1) / BSZ;
    assign base_tab[g]  = PW'(BASE);
    assign end_tab[g]   = PW'(REND);
    assign bsz_tab[g]   = BW'(BSZ);
    assign rcp_tab[g]   = OW'(RCP);
    assign first_tab[g] = SW'(g * BLOCKS_PER_CLASS);
  end

  logic [SW-1:0]     heads [NUM_CLASSES];
  logic [SW-1:0]     links [TOTAL];
  logic [SW-1:0]     rd_data;

  logic              op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CW-1:0]     cls_r;
  logic              zero_r;
  logic              over_r;

  logic [SW-1:0]     head_r;
  logic [ADDR_W-1:0] grant_r;
  logic [OW-1:0]     off_r;
  logic              in_range_r;
  logic [BW-1:0]     bsz_r;
  logic [OW-1:0]     rcp_r;
  logic [QW-1:0]     qe_r;
  logic [PRW-1:0]    prod_r;

  logic [SAW-1:0]    init_s;
  logic [KW-1:0]     init_k;

  status_t           res_status;
  logic [ADDR_W-1:0] res_grant;

  // class decode at accept
  logic [CW-1:0] cls_in;
  always_comb begin
    cls_in = '0;
    for (int j = 1; j < NUM_CLASSES; j++) begin
      if (request_size > SIZE_W'(j * MIN_BLOCK)) begin
        cls_in = cls_in + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= opcode;
      addr_r <= block_address;
      cls_r  <= cls_in;
      zero_r <= (request_size == '0);
      over_r <= (request_size > SIZE_W'(MAX_BSZ));
    end
  end

  // class lookup
  logic [SW-1:0]      head_sel;
  logic [SW-1:0]      k_diff;
  logic [KW+BW-1:0]   kb;
  logic [PW-1:0]      grant_sum;
  logic [XW-1:0]      addr_x;
  logic [XW-1:0]      base_x;
  logic [XW-1:0]      end_x;
  logic [XW-1:0]      off_x;

  always_comb begin
    head_sel  = heads[cls_r];
    k_diff    = head_sel - first_tab[cls_r];
    kb        = k_diff[KW-1:0] * bsz_tab[cls_r];
    grant_sum = base_tab[cls_r] + PW'(kb);
    addr_x    = XW'(addr_r);
    base_x    = XW'(base_tab[cls_r]);
    end_x     = XW'(end_tab[cls_r]);
    off_x     = addr_x - base_x;
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      head_r     <= head_sel;
      grant_r    <= ADDR_W'(grant_sum);
      off_r      <= off_x[OW-1:0];
      in_range_r <= (addr_x >= base_x) && (addr_x < end_x);
      bsz_r      <= bsz_tab[cls_r];
      rcp_r      <= rcp_tab[cls_r];
    end
  end

  // slot from offset: reciprocal estimate, then exact check
  logic [2*OW-1:0]  prod1;
  logic [QW+BW-1:0] prod2;
  assign prod1 = off_r * rcp_r;
  assign prod2 = qe_r * bsz_r;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      qe_r <= prod1[OW +: QW];
    end
    if (cmd.mul2) begin
      prod_r <= PRW'(prod2);
    end
  end

  logic [PRW-1:0] off_e;
  logic [PRW-1:0] prod_dn;
  logic           hit0;
  logic           hit1;
  logic [QW-1:0]  k_q;
  logic [SW-1:0]  slot;

  always_comb begin
    off_e   = PRW'(off_r);
    prod_dn = prod_r - PRW'(bsz_r);
    hit0    = (prod_r == off_e);
    hit1    = (prod_r > off_e) && (prod_dn == off_e);
    k_q     = hit0 ? qe_r : (qe_r - QW'(1));
    slot    = first_tab[cls_r] + SW'(k_q[KW-1:0]);
  end

  // free-list heads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads[i] <= SW'(i * BLOCKS_PER_CLASS);
      end
    end else if (cmd.pop) begin
      heads[cls_r] <= rd_data;
    end else if (cmd.push) begin
      heads[cls_r] <= slot;
    end
  end

  // link memory and its initialising sweep
  logic           mem_we;
  logic [SAW-1:0] mem_waddr;
  logic [SW-1:0]  mem_wdata;
  logic [SW-1:0]  init_link;

  assign init_link = (init_k == KW'(BLOCKS_PER_CLASS - 1)) ? SW'(NULL_SLOT)
                                                           : (SW'(init_s) + SW'(1));
  assign mem_we    = cmd.init_step | cmd.push;
  assign mem_waddr = cmd.init_step ? init_s : slot[SAW-1:0];
  assign mem_wdata = cmd.init_step ? init_link : heads[cls_r];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      links[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_link) begin
      rd_data <= links[head_r[SAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_s <= '0;
      init_k <= '0;
    end else if (cmd.init_step) begin
      init_s <= init_s + SAW'(1);
      init_k <= (init_k == KW'(BLOCKS_PER_CLASS - 1)) ? '0 : (init_k + KW'(1));
    end
  end

  // result and output register
  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_status <= cmd.res_status;
      res_grant  <= cmd.res_grant ? grant_r : '0;
    end
    if (cmd.load_out) begin
      status          <= res_status;
      granted_address <= res_grant;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    sts.zero      = zero_r;
    sts.over      = over_r;
    sts.is_free   = (op_r == OP_FREE);
    sts.head_null = (head_r == SW'(NULL_SLOT));
    sts.in_range  = in_range_r;
    sts.aligned   = hit0 | hit1;
    sts.init_last = (init_s == SAW'(TOTAL - 1));
    sts.out_free  = !m_tvalid || m_tready;
  end

endmodule

>>> hw/rtl/size_class_free_list_allocator_unit.sv
// Channel  Dir  Fields (low bit first)
// s_*      in   tuser: opcode; tdata: request_size[15:0], block_address[28:16]
// m_*      out  tdata: granted_address[12:0], status[14:13]
//
// After reset the link memory is swept with s_tready low. One request is in flight at a
// time: a granted allocate passes through the head lookup and the registered link read,
// an in-region free through the head lookup and the two multiplies of the offset-to-slot
// reciprocal divide, and a zero or oversize request, an empty class or an out-of-region
// free through the head lookup alone.
// A result waiting on m_tready holds the output register; the next request waits in its final step.
module size_class_free_list_allocator_unit #(
  parameter int NUM_CLASSES      = 8,
  parameter int MIN_BLOCK        = 8,
  parameter int BLOCKS_PER_CLASS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // request_size, block_address
  input  logic        s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // granted_address, status
);
  import scfla_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [ADDR_W-1:0] granted_address;
  status_t           status;

  scfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scfla_dp #(
    .NUM_CLASSES      (NUM_CLASSES),
    .MIN_BLOCK        (MIN_BLOCK),
    .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .opcode          (s_tuser),
    .request_size    (s_tdata[15:0]),
    .block_address   (s_tdata[28:16]),
    .m_tready        (m_tready),
    .m_tvalid        (m_tvalid),
    .granted_address (granted_address),
    .status          (status)
  );

  assign m_tdata = {1'b0, status, granted_address};

endmodule

>>> bench/tb_size_class_free_list_allocator_unit.sv
`timescale 1ns / 100ps

module tb_size_class_free_list_allocator_unit;
  import scfla_pkg::*;

  localparam int NUM_CLASSES      = 8;
  localparam int MIN_BLOCK        = 8;
  localparam int BLOCKS_PER_CLASS = 16;
  localparam int NULL_SLOT        = NUM_CLASSES * BLOCKS_PER_CLASS;
  localparam int MAX_SIZE         = NUM_CLASSES * MIN_BLOCK;
  localparam int RAND_REQUESTS    = 1100;
  localparam int LONG_HOLD        = 300;
  localparam int DRAIN_CYCLES     = 20;
  localparam int LIMIT_CYCLES     = 300000;
  localparam logic OP_ALLOC       = 1'b0;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           st;
  } grant_t;

  class free_list_tracker;
    logic [7:0] heads[NUM_CLASSES];
    logic [7:0] links[NULL_SLOT];
    grant_t     pending[$];
    int         mismatches;
    int         checked;
    int         n_alloc_ok, n_free_ok, n_oversize, n_exhausted, n_bad;

    function new();
      for (int c = 0; c < NUM_CLASSES; c++) begin
        heads[c] = 8'(c * BLOCKS_PER_CLASS);
        for (int k = 0; k < BLOCKS_PER_CLASS; k++) begin
          links[c * BLOCKS_PER_CLASS + k] =
            8'((k + 1 < BLOCKS_PER_CLASS) ? c * BLOCKS_PER_CLASS + k + 1 : NULL_SLOT);
        end
      end
    endfunction

    function grant_t take_request(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
      grant_t g;
      int c, base, bsz, slot, a;
      g.addr = '0;
      g.st   = ST_OK;
      a      = int'(addr);
      if (size == 0) begin
        g.st = ST_BAD;
      end else if (int'(size) > MAX_SIZE) begin
        g.st = ST_OVERSIZE;
      end else begin
        c    = (int'(size) - 1) / MIN_BLOCK;
        base = MIN_BLOCK * BLOCKS_PER_CLASS * (c * (c + 1) / 2);
        bsz  = (c + 1) * MIN_BLOCK;
        if (op != OP_FREE) begin
          if (int'(heads[c]) >= NULL_SLOT) begin
            g.st = ST_EXHAUSTED;
          end else begin
            g.addr   = ADDR_W'(base + (int'(heads[c]) - c * BLOCKS_PER_CLASS) * bsz);
            heads[c] = links[heads[c]];
          end
        end else if (a < base || a >= base + bsz * BLOCKS_PER_CLASS || (a - base) % bsz != 0) begin
          g.st = ST_BAD;
        end else begin
          slot        = c * BLOCKS_PER_CLASS + (a - base) / bsz;
          links[slot] = heads[c];
          heads[c]    = 8'(slot);
        end
      end
      case (g.st)
        ST_OK:        if (op == OP_FREE) n_free_ok++; else n_alloc_ok++;
        ST_OVERSIZE:  n_oversize++;
        ST_EXHAUSTED: n_exhausted++;
        default:      n_bad++;
      endcase
      pending.push_back(g);
      return g;
    endfunction

    function void flag(string msg);
      if (mismatches < 10) $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
    endfunction

    function void match_grant(logic [15:0] data);
      grant_t g;
      checked++;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result %h", data));
        return;
      end
      g = pending.pop_front();
      if (data[ADDR_W-1:0] !== g.addr)
        flag($sformatf("granted_address exp %0d got %0d", g.addr, data[ADDR_W-1:0]));
      if (data[ADDR_W +: STATUS_W] !== g.st)
        flag($sformatf("status exp %0d got %0d", g.st, data[ADDR_W +: STATUS_W]));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  free_list_tracker tracker;
  int               sent;
  int               cycles;
  logic [ADDR_W-1:0] live_addr[$];
  int               live_cls[$];

  size_class_free_list_allocator_unit #(
    .NUM_CLASSES(NUM_CLASSES),
    .MIN_BLOCK(MIN_BLOCK),
    .BLOCKS_PER_CLASS(BLOCKS_PER_CLASS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL size_class_free_list_allocator_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_grant(m_tdata);
  end

  task automatic issue(logic op, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ad);
    grant_t g;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, ad, sz};
    do @(posedge clk); while (!s_tready);
    g = tracker.take_request(op, sz, ad);
    sent++;
    if (op != OP_FREE && g.st == ST_OK) begin
      live_addr.push_back(g.addr);
      live_cls.push_back((int'(sz) - 1) / MIN_BLOCK);
    end
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: stall pattern is redrawn at random, one long hold-off
  initial begin
    int mode, left;
    bit held;
    mode     = 0;
    left     = 0;
    held     = 0;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!held && sent >= 500) begin
        held = 1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 100);
      end
      left--;
      case (mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ~m_tready;
      endcase
      @(posedge clk);
    end
  end

  initial begin
    int burst, kind, alloc_w, fav, idx, c, last_cls;
    bit have_last;
    logic op;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] ad, last_addr;
    tracker   = new();
    sent      = 0;
    burst     = 0;
    alloc_w   = 50;
    fav       = 0;
    have_last = 0;
    last_cls  = 0;
    last_addr = '0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // zero size, oversize, address and size extremes
    issue(OP_ALLOC, 16'd0, 13'd0);
    issue(OP_FREE, 16'd0, 13'd0);
    issue(OP_ALLOC, 16'd65, 13'h1FFF);
    issue(OP_ALLOC, 16'hFFFF, 13'd0);
    issue(OP_FREE, 16'h8000, 13'h1FFF);
    // allocates in every class, class edges
    issue(OP_ALLOC, 16'd1, 13'd0);
    issue(OP_ALLOC, 16'd8, 13'd0);
    issue(OP_ALLOC, 16'd9, 13'd0);
    issue(OP_ALLOC, 16'd24, 13'd0);
    issue(OP_ALLOC, 16'd25, 13'd0);
    issue(OP_ALLOC, 16'd33, 13'd0);
    issue(OP_ALLOC, 16'd40, 13'd0);
    issue(OP_ALLOC, 16'd48, 13'd0);
    issue(OP_ALLOC, 16'd56, 13'd0);
    issue(OP_ALLOC, 16'd57, 13'd0);
    issue(OP_ALLOC, 16'd64, 13'h1FFF);
    // valid frees, misaligned and out-of-region frees
    issue(OP_FREE, 16'd64, 13'd3584);
    issue(OP_FREE, 16'd1, 13'd0);
    issue(OP_FREE, 16'd16, 13'd131);
    issue(OP_FREE, 16'd8, 13'd128);
    issue(OP_FREE, 16'd64, 13'h1FFF);
    // double free hands the same block out twice
    issue(OP_FREE, 16'd1, 13'd0);
    issue(OP_ALLOC, 16'd1, 13'd0);
    issue(OP_ALLOC, 16'd1, 13'd0);
    live_addr.delete();
    live_cls.delete();

    for (int i = 0; i < RAND_REQUESTS; i++) begin
      if (i % 200 == 0) begin
        alloc_w = $urandom_range(20, 95);
        fav     = $urandom_range(0, NUM_CLASSES - 1);
      end
      if (burst == 0) begin
        pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst = $urandom_range(1, 30);
      end
      burst--;
      kind = $urandom_range(0, 99);
      ad   = ADDR_W'($urandom_range(0, 8191));
      op   = OP_ALLOC;
      if (kind < 15) begin
        case ($urandom_range(0, 3))
          0: begin
            op = 1'($urandom_range(0, 1));
            sz = '0;
          end
          1: begin
            op = 1'($urandom_range(0, 1));
            sz = SIZE_W'($urandom_range(MAX_SIZE + 1, 65535));
          end
          2: begin
            op = OP_FREE;
            sz = SIZE_W'($urandom_range(1, MAX_SIZE));
          end
          default: begin
            op = OP_FREE;
            sz = SIZE_W'($urandom_range(1, MAX_SIZE));
            if (have_last) begin
              ad = last_addr;
              sz = SIZE_W'(last_cls * MIN_BLOCK + $urandom_range(1, MIN_BLOCK));
            end
          end
        endcase
      end else if (kind < 15 + alloc_w * 85 / 100 || live_addr.size() == 0) begin
        if ($urandom_range(0, 1) == 0)
          sz = SIZE_W'(fav * MIN_BLOCK + $urandom_range(1, MIN_BLOCK));
        else
          sz = SIZE_W'($urandom_range(1, MAX_SIZE));
      end else begin
        idx = $urandom_range(0, live_addr.size() - 1);
        ad  = live_addr[idx];
        c   = live_cls[idx];
        live_addr.delete(idx);
        live_cls.delete(idx);
        op        = OP_FREE;
        sz        = SIZE_W'(c * MIN_BLOCK + $urandom_range(1, MIN_BLOCK));
        last_addr = ad;
        last_cls  = c;
        have_last = 1;
      end
      issue(op, sz, ad);
    end
    s_tvalid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests %0d, results %0d: %0d allocated, %0d freed", sent, tracker.checked,
             tracker.n_alloc_ok, tracker.n_free_ok);
    $display("rejected: %0d oversize, %0d exhausted, %0d bad size or address; mismatches %0d",
             tracker.n_oversize, tracker.n_exhausted, tracker.n_bad, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("PASS size_class_free_list_allocator_unit");
    end else begin
      $display("FAIL size_class_free_list_allocator_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/scfla_pkg.sv
hw/rtl/scfla_ctrl.sv
hw/rtl/scfla_dp.sv
hw/rtl/size_class_free_list_allocator_unit.sv
bench/tb_size_class_free_list_allocator_unit.sv
